// ===== rtl/gst_pkg.sv =====
package gst_pkg;

  localparam int SAMPLE_W = 12;
  localparam int STAMP_W  = 32;
  localparam int SPEED_W  = 8;
  localparam int SLOT_W   = 4;
  localparam int QUOT_W   = 36;
  localparam int STEP_W   = 6;
  localparam int DIV_STEPS = 36;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_FIRST_THR  = 3'd0;
  localparam logic [2:0] REG_SECOND_THR = 3'd1;
  localparam logic [2:0] REG_NUMERATOR  = 3'd2;
  localparam logic [2:0] REG_CORRECTION = 3'd3;
  localparam logic [2:0] REG_LIMIT      = 3'd4;
  localparam logic [2:0] REG_TIMEOUT    = 3'd5;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic SENSOR_FIRST  = 1'b0;
  localparam logic SENSOR_SECOND = 1'b1;

  typedef struct packed {
    logic                sensor_id;
    logic [SAMPLE_W-1:0] sample;
    logic [STAMP_W-1:0]  stamp;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [SPEED_W-1:0] speed;
    logic               over_limit;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] first_threshold;
    logic [SAMPLE_W-1:0] second_threshold;
    logic [31:0]         speed_numerator;
    logic [7:0]          correction_q4;
    logic [11:0]         limit_q4;
    logic [15:0]         timeout_samples;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic corr;
    logic rec;
    logic flush_rd;
    logic flush_wr;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic div_last;
    logic out_free;
    logic buf_full;
    logic flush_last;
  } status_t;

endpackage

// ===== rtl/two_gate_speed_trap_top.sv =====
// Sequence: a sample that arms, counts or is ignored leaves the block idle; a sample
//   that ends a measurement yields its record beat (36-step divider, then correction
//   and record stages), and a full buffer adds a read and a write state per flush beat.
// Throughput: 1 sample per cycle until a measurement completes; samples are then held
//   off until the serial divider, the record and any flush through the buffer port finish.
// Reset (rst, synchronous): idle and unarmed, buffer fill at slot 0, registers at defaults.
module two_gate_speed_trap_top #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // sample channel
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  gst_pkg::in_t                sample_data,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output gst_pkg::out_t               result_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gst_pkg::ADDR_W-1:0]  paddr,
  input  logic [gst_pkg::DATA_W-1:0]  pwdata,
  output logic [gst_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  gst_pkg::cfg_t    cfg;
  gst_pkg::cmd_t    cmd;
  gst_pkg::status_t status;
  logic [2:0]       reg_index;
  logic             cfg_write;

  // Register file: one word per register, written on the access phase.
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_threshold  <= 12'd429;
      cfg.second_threshold <= 12'd273;
      cfg.speed_numerator  <= 32'd80928000;
      cfg.correction_q4    <= 8'd8;
      cfg.limit_q4         <= 12'd48;
      cfg.timeout_samples  <= 16'd1000;
    end else if (cfg_write) begin
      unique case (reg_index)
        gst_pkg::REG_FIRST_THR:  cfg.first_threshold  <= pwdata[11:0];
        gst_pkg::REG_SECOND_THR: cfg.second_threshold <= pwdata[11:0];
        gst_pkg::REG_NUMERATOR:  cfg.speed_numerator  <= pwdata;
        gst_pkg::REG_CORRECTION: cfg.correction_q4    <= pwdata[7:0];
        gst_pkg::REG_LIMIT:      cfg.limit_q4         <= pwdata[11:0];
        gst_pkg::REG_TIMEOUT:    cfg.timeout_samples  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back: zero-extend each register, unmapped addresses read zero.
  always_comb begin
    unique case (reg_index)
      gst_pkg::REG_FIRST_THR:  prdata = gst_pkg::DATA_W'(cfg.first_threshold);
      gst_pkg::REG_SECOND_THR: prdata = gst_pkg::DATA_W'(cfg.second_threshold);
      gst_pkg::REG_NUMERATOR:  prdata = cfg.speed_numerator;
      gst_pkg::REG_CORRECTION: prdata = gst_pkg::DATA_W'(cfg.correction_q4);
      gst_pkg::REG_LIMIT:      prdata = gst_pkg::DATA_W'(cfg.limit_q4);
      gst_pkg::REG_TIMEOUT:    prdata = gst_pkg::DATA_W'(cfg.timeout_samples);
      default:                 prdata = '0;
    endcase
  end

  // Sequencer: accept samples while idle, step the divider, issue record and flush beats.
  gst_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Datapath: arming state, divider, correction, speed buffer and output register.
  gst_dp #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .sample_data (sample_data),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data)
  );

  // A beat that completes a measurement holds off further samples.
  a_hit_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && status.hit |=> sample_stall)
    else $error("measurement beat did not start the divider");

  // Any other sample beat leaves the block ready for the next one.
  a_miss_ready: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && !status.hit |=> !sample_stall)
    else $error("non-measuring beat stalled the sample channel");

  // The sequencer only loads the output register when it is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> !$past(cmd.rec || cmd.flush_wr))
    else $error("output register overwritten while stalled");

endmodule

// ===== rtl/gst_ram.sv =====
module gst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gst_dp.sv =====
module gst_dp #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  gst_pkg::cfg_t    cfg,
  input  gst_pkg::in_t     sample_data,
  input  gst_pkg::cmd_t    cmd,
  output gst_pkg::status_t status,
  output logic             result_valid,
  input  logic             result_stall,
  output gst_pkg::out_t    result_data
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);

  // measurement state
  logic                          armed;
  logic [gst_pkg::STAMP_W-1:0]   start_stamp;
  logic [15:0]                   wait_count;
  logic [15:0]                   wait_inc;
  logic [IDX_W-1:0]              fill_index;
  logic [IDX_W-1:0]              flush_index;
  logic                          zero_ticks;
  logic [gst_pkg::STAMP_W-1:0]   ticks;

  // shift-subtract divider
  logic [gst_pkg::STAMP_W-1:0]   rem;
  logic [gst_pkg::QUOT_W-1:0]    quot;
  logic [gst_pkg::STEP_W-1:0]    div_cnt;
  logic [gst_pkg::STAMP_W:0]     rem_sh;
  logic [gst_pkg::STAMP_W:0]     rem_diff;
  logic                          qbit;

  logic [gst_pkg::QUOT_W-1:0]    speed_q4;
  logic [gst_pkg::SPEED_W-1:0]   spd;
  logic                          over;
  logic [gst_pkg::SPEED_W-1:0]   ram_rdata;

  logic trip_first;
  logic trip_second;

  assign trip_first  = sample_data.sample < cfg.first_threshold;
  assign trip_second = sample_data.sample < cfg.second_threshold;
  assign wait_inc    = wait_count + 16'd1;

  assign status.hit        = armed && (sample_data.sensor_id == gst_pkg::SENSOR_SECOND)
                             && trip_second;
  assign status.div_last   = div_cnt == gst_pkg::STEP_W'(gst_pkg::DIV_STEPS - 1);
  assign status.out_free   = !result_valid || !result_stall;
  assign status.buf_full   = fill_index == IDX_LAST;
  assign status.flush_last = flush_index == IDX_LAST;

  assign rem_sh   = {rem, quot[gst_pkg::QUOT_W-1]};
  assign rem_diff = rem_sh - {1'b0, ticks};
  assign qbit     = !rem_diff[gst_pkg::STAMP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      start_stamp <= '0;
      wait_count  <= '0;
    end else if (cmd.accept) begin
      if (!armed) begin
        if (sample_data.sensor_id == gst_pkg::SENSOR_FIRST && trip_first) begin
          armed       <= 1'b1;
          start_stamp <= sample_data.stamp;
          wait_count  <= '0;
        end
      end else if (sample_data.sensor_id == gst_pkg::SENSOR_SECOND) begin
        if (!trip_second) begin
          if (wait_inc >= cfg.timeout_samples) begin
            armed      <= 1'b0;
            wait_count <= '0;
          end else begin
            wait_count <= wait_inc;
          end
        end else begin
          armed      <= 1'b0;
          wait_count <= '0;
        end
      end
    end
  end

  // divider: load on a hit, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.accept && status.hit) begin
      ticks      <= sample_data.stamp - start_stamp;
      zero_ticks <= sample_data.stamp == start_stamp;
      rem        <= '0;
      quot       <= {cfg.speed_numerator, 4'b0000};
      div_cnt    <= '0;
    end else if (cmd.div_step) begin
      rem     <= qbit ? rem_diff[gst_pkg::STAMP_W-1:0] : rem_sh[gst_pkg::STAMP_W-1:0];
      quot    <= {quot[gst_pkg::QUOT_W-2:0], qbit};
      div_cnt <= div_cnt + gst_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.corr) begin
      speed_q4 <= (quot > gst_pkg::QUOT_W'(cfg.correction_q4))
                  ? quot - gst_pkg::QUOT_W'(cfg.correction_q4) : '0;
    end
  end

  always_comb begin
    if (zero_ticks) begin
      spd  = '1;
      over = 1'b1;
    end else begin
      over = speed_q4 > gst_pkg::QUOT_W'(cfg.limit_q4);
      spd  = (|speed_q4[gst_pkg::QUOT_W-1:12]) ? '1 : speed_q4[11:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index  <= '0;
      flush_index <= '0;
    end else if (cmd.rec) begin
      fill_index  <= status.buf_full ? '0 : fill_index + IDX_W'(1);
      flush_index <= '0;
    end else if (cmd.flush_wr) begin
      flush_index <= flush_index + IDX_W'(1);
    end
  end

  gst_ram #(
    .WIDTH(gst_pkg::SPEED_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.rec),
    .waddr(fill_index),
    .wdata(spd),
    .re   (cmd.flush_rd),
    .raddr(flush_index),
    .rdata(ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.rec || cmd.flush_wr) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec) begin
      result_data.kind       <= gst_pkg::KIND_RECORD;
      result_data.speed      <= spd;
      result_data.over_limit <= over;
      result_data.slot       <= gst_pkg::SLOT_W'(fill_index);
      result_data.last       <= 1'b0;
    end else if (cmd.flush_wr) begin
      result_data.kind       <= gst_pkg::KIND_FLUSH;
      result_data.speed      <= ram_rdata;
      result_data.over_limit <= 1'b0;
      result_data.slot       <= gst_pkg::SLOT_W'(flush_index);
      result_data.last       <= status.flush_last;
    end
  end

endmodule

// ===== rtl/gst_ctrl.sv =====
module gst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  gst_pkg::status_t status,
  output gst_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CORR = 3'd2;
  localparam logic [2:0] S_REC  = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FWR  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign sample_stall = state != S_IDLE;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = sample_valid;
        if (sample_valid && status.hit) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CORR;
        end
      end
      S_CORR: begin
        cmd.corr   = 1'b1;
        state_next = S_REC;
      end
      S_REC: begin
        if (status.out_free) begin
          cmd.rec    = 1'b1;
          state_next = status.buf_full ? S_FRD : S_IDLE;
        end
      end
      S_FRD: begin
        cmd.flush_rd = 1'b1;
        state_next   = S_FWR;
      end
      S_FWR: begin
        if (status.out_free) begin
          cmd.flush_wr = 1'b1;
          state_next   = status.flush_last ? S_IDLE : S_FRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
